// File: sv/tlvpa_pkg.sv
// Package for the TLV packet assembler: shared codes, types and constants.
// Used by tlvpa_ctrl, tlvpa_dp and tlv_packet_assembler_top; no dependencies.
`default_nettype none
package tlvpa_pkg;

  localparam int STORE_LIMIT = 60;   // largest store that keeps a frame within 63 words
  localparam int USED_W      = 6;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_SEND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RX_ADDR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_ADDR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_READY = 2'd2;

  localparam logic [7:0] RX_ADDR_RST = 8'h15;
  localparam logic [7:0] TX_ADDR_RST = 8'h14;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ADD_WR  = 8'b0000_0010,
    S_ADD_ST  = 8'b0000_0100,
    S_SND_RA  = 8'b0000_1000,
    S_SND_SA  = 8'b0001_0000,
    S_SND_CNT = 8'b0010_0000,
    S_SND_RD  = 8'b0100_0000,
    S_SND_DAT = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    SEL_STAT = 3'd0,
    SEL_RA   = 3'd1,
    SEL_SA   = 3'd2,
    SEL_CNT  = 3'd3,
    SEL_DATA = 3'd4
  } out_sel_t;

  typedef struct packed {
    logic     latch_in;    // capture input word, clear byte counters
    logic     clear_used;  // empty the store
    logic     wr_en;       // write one element byte
    logic     k_inc;       // advance element byte counter
    logic     commit_add;  // bump fill count if the add fits
    logic     rd_en;       // read one stored byte
    logic     idx_inc;     // advance read index
    logic     out_load;    // load the output register
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic add_done;
    logic rd_last;
    logic used_zero;
    logic link_ready;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/tlvpa_ctrl.sv
// Controller state machine of the TLV packet assembler.
// Depends on tlvpa_pkg; drives commands to tlvpa_dp and reads its status.
`default_nettype none
module tlvpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_mode,
  output logic                   in_stall,
  input  wire tlvpa_pkg::sts_t   sts,
  output tlvpa_pkg::cmd_t        cmd
);
  import tlvpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = SEL_STAT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_mode)
            MODE_CLEAR: cmd.clear_used = 1'b1;
            MODE_ADD:   state_nxt = S_ADD_WR;
            MODE_SEND: begin
              if (sts.link_ready && !sts.used_zero) state_nxt = S_SND_RA;
            end
            default: ;
          endcase
        end
      end
      S_ADD_WR: begin
        if (!sts.add_ok) begin
          state_nxt = S_ADD_ST;
        end else begin
          cmd.wr_en = 1'b1;
          if (sts.add_done) state_nxt = S_ADD_ST;
          else cmd.k_inc = 1'b1;
        end
      end
      S_ADD_ST: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = SEL_STAT;
          cmd.commit_add = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SND_RA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_RA;
          state_nxt    = S_SND_SA;
        end
      end
      S_SND_SA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_SA;
          state_nxt    = S_SND_CNT;
        end
      end
      S_SND_CNT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_CNT;
          state_nxt    = S_SND_RD;
        end
      end
      S_SND_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SND_DAT;
      end
      S_SND_DAT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DATA;
          if (sts.rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SND_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/tlvpa_dp.sv
// Datapath of the TLV packet assembler: payload memory, fill count,
// configuration registers and output register. Depends on tlvpa_pkg.
`default_nettype none
module tlvpa_dp #(
  parameter int PAYLOAD_BYTES = 60
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_elem_type,
  input  wire logic [2:0]                    in_elem_len,
  input  wire logic [31:0]                   in_elem_value,
  input  wire logic                          cfg_we,
  input  wire logic [tlvpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tlvpa_pkg::CFG_W-1:0]   cfg_data,
  input  wire tlvpa_pkg::cmd_t               cmd,
  output tlvpa_pkg::sts_t                    sts,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_is_frame_byte,
  output logic [7:0]                         out_frame_byte,
  output logic                               out_last_byte,
  output logic                               out_add_accepted
);
  import tlvpa_pkg::*;

  localparam int CAP = (PAYLOAD_BYTES > STORE_LIMIT) ? STORE_LIMIT : PAYLOAD_BYTES;
  localparam int AW  = $clog2(CAP);

  logic [7:0]        mem [CAP];
  logic [7:0]        rd_q_r;

  logic [7:0]        rx_addr_r, tx_addr_r;
  logic              link_ready_r;
  logic [USED_W-1:0] used_r;
  logic [7:0]        type_r;
  logic [2:0]        len_r;
  logic [31:0]       value_r;
  logic [2:0]        k_r;
  logic [USED_W-1:0] idx_r;

  logic              out_valid_r;
  logic              out_isf_r, out_last_r, out_acc_r;
  logic [7:0]        out_byte_r;

  logic [USED_W:0]   add_sum;
  logic              len_ok, add_ok;
  logic [USED_W-1:0] wr_sum;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        wr_byte;
  logic              out_free;
  logic              rd_last;

  // Fit check: the length must be 1..4 and the new element must not run past the store capacity.
  assign len_ok  = (len_r != 3'd0) && (len_r <= 3'd4);
  assign add_sum = {1'b0, used_r} + (USED_W+1)'(2) + {{(USED_W-2){1'b0}}, len_r};
  assign add_ok  = len_ok && (add_sum <= (USED_W+1)'(CAP));

  assign wr_sum  = used_r + {{(USED_W-3){1'b0}}, k_r};
  assign wr_addr = wr_sum[AW-1:0];
  assign rd_addr = idx_r[AW-1:0];
  assign rd_last = ({1'b0, idx_r} + (USED_W+1)'(1)) == {1'b0, used_r};

  always_comb begin
    case (k_r)
      3'd0:    wr_byte = type_r;
      3'd1:    wr_byte = {5'd0, len_r};
      3'd2:    wr_byte = value_r[7:0];
      3'd3:    wr_byte = value_r[15:8];
      3'd4:    wr_byte = value_r[23:16];
      3'd5:    wr_byte = value_r[31:24];
      default: wr_byte = 8'd0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts            = '0;
    sts.add_ok     = add_ok;
    sts.add_done   = ({1'b0, k_r} == ({1'b0, len_r} + 4'd1));
    sts.rd_last    = rd_last;
    sts.used_zero  = (used_r == '0);
    sts.link_ready = link_ready_r;
    sts.out_free   = out_free;
  end

  // Payload memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_byte;
    if (cmd.rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_addr_r    <= RX_ADDR_RST;
      tx_addr_r    <= TX_ADDR_RST;
      link_ready_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RX_ADDR:    rx_addr_r    <= cfg_data;
        CFG_TX_ADDR:    tx_addr_r    <= cfg_data;
        CFG_LINK_READY: link_ready_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      type_r  <= in_elem_type;
      len_r   <= in_elem_len;
      value_r <= in_elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      k_r    <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.clear_used) used_r <= '0;
      else if (cmd.commit_add && add_ok) used_r <= add_sum[USED_W-1:0];
      if (cmd.latch_in) k_r <= '0;
      else if (cmd.k_inc) k_r <= k_r + 3'd1;
      if (cmd.latch_in) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + (USED_W)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        SEL_STAT: begin
          out_isf_r  <= 1'b0;
          out_byte_r <= 8'd0;
          out_last_r <= 1'b0;
          out_acc_r  <= add_ok;
        end
        SEL_RA: begin
          out_isf_r  <= 1'b1;
          out_byte_r <= rx_addr_r;
          out_last_r <= 1'b0;
          out_acc_r  <= 1'b0;
        end
        SEL_SA: begin
          out_isf_r  <= 1'b1;
          out_byte_r <= tx_addr_r;
          out_last_r <= 1'b0;
          out_acc_r  <= 1'b0;
        end
        SEL_CNT: begin
          out_isf_r  <= 1'b1;
          out_byte_r <= {{(8-USED_W){1'b0}}, used_r};
          out_last_r <= 1'b0;
          out_acc_r  <= 1'b0;
        end
        SEL_DATA: begin
          out_isf_r  <= 1'b1;
          out_byte_r <= rd_q_r;
          out_last_r <= rd_last;
          out_acc_r  <= 1'b0;
        end
        default: begin
          out_isf_r  <= 1'b0;
          out_byte_r <= 8'd0;
          out_last_r <= 1'b0;
          out_acc_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_frame_byte = out_isf_r;
  assign out_frame_byte    = out_byte_r;
  assign out_last_byte     = out_last_r;
  assign out_add_accepted  = out_acc_r;

endmodule
`default_nettype wire

// File: sv/tlv_packet_assembler_top.sv
// TLV packet assembler: top level joining controller and datapath.
// Depends on tlvpa_pkg, tlvpa_ctrl and tlvpa_dp.
//
// Usage:
//  - Input channel (in_valid / in_stall) takes one word per command:
//    clear (empty the store), add (append type, length, 1..4 value bytes,
//    least significant first) or send (stream the frame).
//  - Result channel (out_valid / out_stall) gives an add status word
//    (add_accepted) per add, and per send the receiver address, sender
//    address, count byte and stored bytes, last_byte on the final one.
//  - Steps per command: clear is done on acceptance; add: accept, one memory
//    write per stored byte, status word (accept and status word when rejected);
//    send: accept, three header words, then per stored byte a read and an output
//    load, as set by the single registered memory read port. One at a time.
//  - A send with an empty store or link_ready clear, and mode 3, give no word.
//  - Stall: a stalled result holds in the output register; the controller
//    waits before loading the next word. A finished result may wait while
//    the next command is already taken.
//  - Reset (rst_n low, synchronous): store emptied, addresses 0x15/0x14,
//    link_ready set. Store contents need no clearing.
`default_nettype none
module tlv_packet_assembler_top #(
  parameter int PAYLOAD_BYTES = 60
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_mode,
  input  wire logic [7:0]                      in_elem_type,
  input  wire logic [2:0]                      in_elem_len,
  input  wire logic [31:0]                     in_elem_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_is_frame_byte,
  output logic [7:0]                           out_frame_byte,
  output logic                                 out_last_byte,
  output logic                                 out_add_accepted,
  input  wire logic                            cfg_we,
  input  wire logic [tlvpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tlvpa_pkg::CFG_W-1:0]     cfg_data
);
  import tlvpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlvpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlvpa_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_elem_type      (in_elem_type),
    .in_elem_len       (in_elem_len),
    .in_elem_value     (in_elem_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_frame_byte (out_is_frame_byte),
    .out_frame_byte    (out_frame_byte),
    .out_last_byte     (out_last_byte),
    .out_add_accepted  (out_add_accepted)
  );

endmodule
`default_nettype wire
